// ----- hw/rtl/mips64_special_integer_execute_unit_assert.svh -----
// Assertion macros for the SPECIAL-group execute unit.
`ifndef MIPS64_SPECIAL_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS64_SPECIAL_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MSIE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define MSIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/msie_pkg.sv -----
// Package: function codes and the iterative unit request and status types.
package msie_pkg;
    localparam logic [5:0] F_SLL = 6'h00, F_SRL = 6'h02, F_SRA = 6'h03;
    localparam logic [5:0] F_SLLV = 6'h04, F_SRLV = 6'h06, F_SRAV = 6'h07;
    localparam logic [5:0] F_MFHI = 6'h10, F_MTHI = 6'h11, F_MFLO = 6'h12, F_MTLO = 6'h13;
    localparam logic [5:0] F_DSLLV = 6'h14, F_DSRLV = 6'h16, F_DSRAV = 6'h17;
    localparam logic [5:0] F_MULT = 6'h18, F_MULTU = 6'h19, F_DIV = 6'h1A, F_DIVU = 6'h1B;
    localparam logic [5:0] F_DMULT = 6'h1C, F_DMULTU = 6'h1D, F_DDIV = 6'h1E;
    localparam logic [5:0] F_DDIVU = 6'h1F;
    localparam logic [5:0] F_ADD = 6'h20, F_ADDU = 6'h21, F_SUB = 6'h22, F_SUBU = 6'h23;
    localparam logic [5:0] F_AND = 6'h24, F_OR = 6'h25, F_XOR = 6'h26, F_NOR = 6'h27;
    localparam logic [5:0] F_SLT = 6'h2A, F_SLTU = 6'h2B;
    localparam logic [5:0] F_DADD = 6'h2C, F_DADDU = 6'h2D, F_DSUB = 6'h2E, F_DSUBU = 6'h2F;
    localparam logic [5:0] F_DSLL = 6'h38, F_DSRL = 6'h3A, F_DSRA = 6'h3B;
    localparam logic [5:0] F_DSLL32 = 6'h3C, F_DSRL32 = 6'h3E, F_DSRA32 = 6'h3F;

    // Start request to the mul/div unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        is_signed;
        logic [63:0] a;
        logic [63:0] b;
    } md_req_t;

    // Finish status from the mul/div unit.
    typedef struct packed {
        logic        done;
        logic        busy;
    } md_stat_t;
endpackage

// ----- hw/rtl/mips64_special_integer_execute_unit.sv -----
// Top level: MIPS64 SPECIAL-group integer execute unit with hi/lo.
// Use: present command, rs_value, rt_value, shift_amount with in_valid;
// an item is taken when in_valid is high and in_stall low. Each item gives
// one result item on out_valid/out_stall: rd_value and rd_write.
// ALU, shift and move operations: the result sits in the output register
// the cycle after acceptance; a new item is taken in the same cycle the
// previous result leaves, so these run one item per cycle when the
// receiver does not stall and no multiply or divide is in flight.
// Multiply and divide items go through the shared bit-serial unit:
// 64 steps, one bit per cycle, after the operands are loaded; no new item
// is taken while the unit works. Their result item (rd_write = 0) appears when
// the unit finishes and hi/lo are updated.
// Division by zero leaves hi and lo as they were.
// Reset clears hi, lo and the output register; no item is pending.
// When the receiver stalls, the result holds and no new item is taken.
module mips64_special_integer_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [5:0]         command,
    input  logic signed [63:0] rs_value,
    input  logic signed [63:0] rt_value,
    input  logic [4:0]         shift_amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] rd_value,
    output logic               rd_write
);
    import msie_pkg::*;

    logic        ov_reg;
    logic [63:0] rd_reg;
    logic        wr_reg;
    logic [63:0] hi_reg, lo_reg;
    logic        wait_reg;   // mul/div in flight
    logic        upd_reg;    // hi/lo update on finish
    logic        w32_reg;
    logic        mdiv_reg;   // in-flight op is a divide
    logic        acc;
    logic [63:0] rs, rt;
    logic [63:0] rd_c;
    logic        wr_c, is_md, is_div, md_word, md_sgn, dz;
    logic [63:0] sx_rt, s32;
    logic [5:0]  sh;
    logic [63:0] t64;
    md_req_t     req;
    md_stat_t    st;
    logic [63:0] md_hi, md_lo;
    logic [31:0] add32, sub32;

    assign in_stall = wait_reg | (ov_reg & out_stall);
    assign acc = in_valid & ~in_stall;
    assign rs = rs_value;
    assign rt = rt_value;

    // Combinational datapath.
    always_comb
    begin
        sx_rt = {{32{rt[31]}}, rt[31:0]};
        add32 = rs[31:0] + rt[31:0];
        sub32 = rs[31:0] - rt[31:0];
        rd_c = 64'd0;
        wr_c = 1'b1;
        s32 = 64'd0;
        t64 = 64'd0;
        sh = 6'd0;
        is_md = 1'b0;
        is_div = 1'b0;
        md_word = 1'b0;
        md_sgn = 1'b0;
        case (command)
            F_SLL, F_SRL, F_SRA, F_SLLV, F_SRLV, F_SRAV:
            begin
                sh = (command[2]) ? {1'b0, rs[4:0]} : {1'b0, shift_amount};
                case (command[1:0])
                    2'b00: s32 = rt << sh;
                    2'b10: s32 = {32'd0, rt[31:0]} >> sh;
                    default: s32 = $signed(sx_rt) >>> sh;
                endcase
                rd_c = {{32{s32[31]}}, s32[31:0]};
            end
            F_DSLLV, F_DSRLV, F_DSRAV, F_DSLL, F_DSRL, F_DSRA,
            F_DSLL32, F_DSRL32, F_DSRA32:
            begin
                if (command[3])
                    sh = {command[2], shift_amount};
                else
                    sh = rs[5:0];
                case (command[1:0])
                    2'b00: t64 = rt << sh;
                    2'b10: t64 = rt >> sh;
                    default: t64 = $signed(rt) >>> sh;
                endcase
                rd_c = t64;
            end
            F_MFHI: rd_c = hi_reg;
            F_MFLO: rd_c = lo_reg;
            F_MTHI, F_MTLO: wr_c = 1'b0;
            F_MULT, F_MULTU, F_DIV, F_DIVU, F_DMULT, F_DMULTU, F_DDIV, F_DDIVU:
            begin
                wr_c = 1'b0;
                is_md = 1'b1;
                is_div = command[1];
                md_word = ~command[2];
                md_sgn = ~command[0];
            end
            F_ADD, F_ADDU: rd_c = {{32{add32[31]}}, add32};
            F_SUB, F_SUBU: rd_c = {{32{sub32[31]}}, sub32};
            F_AND: rd_c = rs & rt;
            F_OR:  rd_c = rs | rt;
            F_XOR: rd_c = rs ^ rt;
            F_NOR: rd_c = ~(rs | rt);
            F_SLT: rd_c = {63'd0, $signed(rs) < $signed(rt)};
            F_SLTU: rd_c = {63'd0, rs < rt};
            F_DADD, F_DADDU: rd_c = rs + rt;
            F_DSUB, F_DSUBU: rd_c = rs - rt;
            default: wr_c = 1'b0;
        endcase
        dz = md_word ? (rt[31:0] == 32'd0) : (rt == 64'd0);
    end

    // Operand setup for the serial unit.
    always_comb
    begin
        req.start = acc & is_md;
        req.is_div = is_div;
        req.is_signed = md_sgn;
        if (md_word)
        begin
            req.a = md_sgn ? {{32{rs[31]}}, rs[31:0]} : {32'd0, rs[31:0]};
            req.b = md_sgn ? sx_rt : {32'd0, rt[31:0]};
        end
        else
        begin
            req.a = rs;
            req.b = rt;
        end
    end

    msie_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (st),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    // Control, output register and hi/lo.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            wait_reg <= 1'b0;
            upd_reg  <= 1'b0;
            w32_reg  <= 1'b0;
            mdiv_reg <= 1'b0;
            rd_reg   <= 64'd0;
            wr_reg   <= 1'b0;
            hi_reg   <= 64'd0;
            lo_reg   <= 64'd0;
        end
        else
        begin
            if (ov_reg & ~out_stall)
                ov_reg <= 1'b0;
            if (acc)
            begin
                if (is_md)
                begin
                    wait_reg <= 1'b1;
                    upd_reg  <= ~(is_div & dz);
                    w32_reg  <= md_word;
                    mdiv_reg <= is_div;
                end
                else
                begin
                    ov_reg <= 1'b1;
                    rd_reg <= wr_c ? rd_c : 64'd0;
                    wr_reg <= wr_c;
                    if (command == F_MTHI)
                        hi_reg <= rs;
                    if (command == F_MTLO)
                        lo_reg <= rs;
                end
            end
            if (st.done)
            begin
                wait_reg <= 1'b0;
                ov_reg   <= 1'b1;
                rd_reg   <= 64'd0;
                wr_reg   <= 1'b0;
                if (upd_reg)
                begin
                    if (w32_reg)
                    begin
                        // word multiply: 64-bit product sits in the low half
                        hi_reg <= mdiv_reg ? {{32{md_hi[31]}}, md_hi[31:0]}
                                           : {{32{md_lo[63]}}, md_lo[63:32]};
                        lo_reg <= {{32{md_lo[31]}}, md_lo[31:0]};
                    end
                    else
                    begin
                        hi_reg <= md_hi;
                        lo_reg <= md_lo;
                    end
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign rd_value  = rd_reg;
    assign rd_write  = wr_reg;

`include "mips64_special_integer_execute_unit_assert.svh"
    `MSIE_ASSERT_IMP(a_no_acc_busy, wait_reg, !acc)
    `MSIE_ASSERT_IMP(a_busy_match, st.busy, wait_reg)
    `MSIE_ASSERT_IMP(a_done_waits, st.done, wait_reg && !ov_reg)
    `MSIE_ASSERT_NEXT(a_md_start, acc && is_md, wait_reg && !ov_reg)
    `MSIE_ASSERT_IMP(a_nowrite_zero, ov_reg && !wr_reg, rd_reg == 64'd0)
endmodule

// ----- hw/rtl/msie_muldiv.sv -----
// Bit-serial multiplier and restoring divider on magnitudes, 64 steps.
module msie_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  msie_pkg::md_req_t   req,
    output msie_pkg::md_stat_t  stat,
    output logic [63:0]         hi,
    output logic [63:0]         lo
);
    import msie_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        div_reg, neg_q_reg, neg_r_reg;
    logic [63:0] acc_reg, acc_next;   // high half / remainder
    logic [63:0] sh_reg, sh_next;     // low half / quotient
    logic [63:0] b_reg;
    logic [63:0] ma, mb;
    logic        na, nb;
    logic [64:0] sum;
    logic [64:0] trial;
    logic [63:0] radd;
    logic [127:0] prod;
    logic [127:0] nprod;

    // Operand magnitudes at start.
    always_comb
    begin
        na = req.is_signed & req.a[63];
        nb = req.is_signed & req.b[63];
        ma = na ? (64'd0 - req.a) : req.a;
        mb = nb ? (64'd0 - req.b) : req.b;
    end

    // One step: shift-add for multiply, shift-subtract for divide.
    always_comb
    begin
        sum   = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, b_reg} : 65'd0);
        radd  = {acc_reg[62:0], sh_reg[63]};
        trial = {acc_reg[63], radd} - {1'b0, b_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            acc_next  = 64'd0;
            sh_next   = ma;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[64])
                begin
                    acc_next = trial[63:0];
                    sh_next  = {sh_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_next = radd;
                    sh_next  = {sh_reg[62:0], 1'b0};
                end
            end
            else
            begin
                acc_next = sum[64:1];
                sh_next  = {sum[0], sh_reg[63:1]};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        if (req.start)
        begin
            b_reg     <= mb;
            div_reg   <= req.is_div;
            neg_q_reg <= na ^ nb;
            neg_r_reg <= na;
        end
    end

    // Sign fix of the finished result.
    always_comb
    begin
        prod  = {acc_reg, sh_reg};
        nprod = 128'd0 - prod;
        if (div_reg)
        begin
            lo = neg_q_reg ? (64'd0 - sh_reg) : sh_reg;
            hi = neg_r_reg ? (64'd0 - acc_reg) : acc_reg;
        end
        else
        begin
            hi = neg_q_reg ? nprod[127:64] : prod[127:64];
            lo = neg_q_reg ? nprod[63:0] : prod[63:0];
        end
    end

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
endmodule
